>>> sv/dhm_pkg.sv
package dhm_pkg;

  localparam int unsigned DHM_CHANNELS    = 512;
  localparam int unsigned DHM_CH_W        = 9;
  localparam int unsigned DHM_LEVEL_W     = 8;
  localparam int unsigned DHM_MASTER_W    = 9;
  localparam int unsigned DHM_DATA_W      = 24;
  localparam int unsigned DHM_QUEUE_DEPTH = 2;

  // one closed channel: index and its master-scaled merged level
  typedef struct packed {
    logic [DHM_CH_W-1:0]    ch;
    logic [DHM_LEVEL_W-1:0] level;
  } dhm_item_t;

  // back-end status seen by the front end
  typedef struct packed {
    logic clearing;
  } dhm_status_t;

endpackage

>>> sv/dhm_ram.sv
module dhm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/dhm_front.sv
module dhm_front #(
  parameter int unsigned CHANNELS = dhm_pkg::DHM_CHANNELS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [dhm_pkg::DHM_CH_W-1:0]      ch_i,
  input  logic [dhm_pkg::DHM_LEVEL_W-1:0]   level_i,
  input  logic                              last_i,
  input  logic                              cfg_we_i,
  input  logic [dhm_pkg::DHM_MASTER_W-1:0]  cfg_wdata_i,
  input  dhm_pkg::dhm_status_t              status_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output dhm_pkg::dhm_item_t                item_o
);
  import dhm_pkg::*;

  localparam int unsigned ProdW = DHM_LEVEL_W + DHM_MASTER_W;

  logic [DHM_MASTER_W-1:0] master_q, master_d;
  logic [DHM_LEVEL_W-1:0]  rmax_q, rmax_d;
  logic                    accept, in_range;
  logic [DHM_LEVEL_W-1:0]  cand;
  logic [ProdW-1:0]        prod;
  logic [DHM_MASTER_W-1:0] scaled;

  assign ready_o  = !status_i.clearing && !q_full_i;
  assign accept   = valid_i && ready_o;
  assign in_range = {1'b0, ch_i} < (DHM_CH_W + 1)'(CHANNELS);

  // htp: highest level of the group wins, out-of-range tags never count
  assign cand   = (in_range && (level_i > rmax_q)) ? level_i : rmax_q;
  assign prod   = ProdW'(cand) * ProdW'(master_q);
  assign scaled = prod[ProdW-1:DHM_LEVEL_W];

  assign push_o       = accept && last_i && in_range;
  assign item_o.ch    = ch_i;
  assign item_o.level = scaled[DHM_MASTER_W-1] ? {DHM_LEVEL_W{1'b1}}
                                               : scaled[DHM_LEVEL_W-1:0];

  always_comb begin
    master_d = cfg_we_i ? cfg_wdata_i : master_q;
    rmax_d   = rmax_q;
    if (accept) begin
      rmax_d = last_i ? '0 : cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= '0;
      rmax_q   <= '0;
    end else begin
      master_q <= master_d;
      rmax_q   <= rmax_d;
    end
  end

endmodule

>>> sv/dhm_queue.sv
module dhm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dhm_pkg::dhm_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output dhm_pkg::dhm_item_t item_o
);
  import dhm_pkg::*;

  localparam int unsigned PtrW = (DHM_QUEUE_DEPTH > 1) ? $clog2(DHM_QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DHM_QUEUE_DEPTH + 1);

  dhm_item_t        entry_q [DHM_QUEUE_DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(DHM_QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DHM_QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DHM_QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> sv/dhm_back.sv
module dhm_back #(
  parameter int unsigned CHANNELS = dhm_pkg::DHM_CHANNELS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  dhm_pkg::dhm_item_t              q_item_i,
  output logic                            pop_o,
  output dhm_pkg::dhm_status_t            status_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dhm_pkg::DHM_CH_W-1:0]    out_ch_o,
  output logic [dhm_pkg::DHM_LEVEL_W-1:0] out_level_o
);
  import dhm_pkg::*;

  localparam int unsigned AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                   clear_q, clear_d;
  logic [AddrW-1:0]       ccnt_q, ccnt_d;
  logic                   s1_valid_q, s1_valid_d;
  dhm_item_t              s1_item_q;
  logic                   fwd_valid_q, fwd_valid_d;
  dhm_item_t              fwd_item_q;
  logic                   out_valid_q, out_valid_d;
  dhm_item_t              out_item_q;
  logic [DHM_LEVEL_W-1:0] rd_data, prev_level;
  logic                   changed, out_free, s1_done, pop;
  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [DHM_LEVEL_W-1:0] ram_wdata;

  dhm_ram #(
    .WIDTH (DHM_LEVEL_W),
    .DEPTH (CHANNELS)
  ) u_sent (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (pop),
    .raddr_i (q_item_i.ch[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  // the item finished in the cycle of the read is not in the table yet
  assign prev_level = (fwd_valid_q && (fwd_item_q.ch == s1_item_q.ch)) ? fwd_item_q.level
                                                                       : rd_data;
  assign changed  = prev_level != s1_item_q.level;
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_done  = s1_valid_q && out_free;
  assign pop      = q_valid_i && (!s1_valid_q || s1_done);
  assign pop_o    = pop;

  assign ram_we    = clear_q || (s1_done && changed);
  assign ram_waddr = clear_q ? ccnt_q : s1_item_q.ch[AddrW-1:0];
  assign ram_wdata = clear_q ? '0 : s1_item_q.level;

  assign status_o.clearing = clear_q;
  assign out_valid_o       = out_valid_q;
  assign out_ch_o          = out_item_q.ch;
  assign out_level_o       = out_item_q.level;

  always_comb begin
    clear_d     = clear_q;
    ccnt_d      = ccnt_q;
    s1_valid_d  = s1_valid_q;
    fwd_valid_d = fwd_valid_q;
    out_valid_d = out_valid_q;
    if (clear_q) begin
      ccnt_d = ccnt_q + 1'b1;
      if (ccnt_q == AddrW'(CHANNELS - 1)) begin
        clear_d = 1'b0;
      end
    end
    if (pop) begin
      s1_valid_d  = 1'b1;
      fwd_valid_d = s1_done;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end
    if (s1_done && changed) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_item_q  <= q_item_i;
      fwd_item_q <= s1_item_q;
    end
    if (s1_done && changed) begin
      out_item_q <= s1_item_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q     <= 1'b1;
      ccnt_q      <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clear_q     <= clear_d;
      ccnt_q      <= ccnt_d;
      s1_valid_q  <= s1_valid_d;
      fwd_valid_q <= fwd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> sv/dmx_htp_merge_master_delta_core.sv
// a closing item is queued, read and compared in stage s1, then held in the output register
// throughput: one item per cycle unless the output stalls, set by the single read/compare/write
//   pass per item over the sent-level table (one read port, one write port, with forwarding)
// reset: async active low; afterwards a clearing pass writes zero to all CHANNELS
//   table entries, one per cycle, with s_axis_tready low
module dmx_htp_merge_master_delta_core #(
  parameter int unsigned CHANNELS = dhm_pkg::DHM_CHANNELS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // source levels
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dhm_pkg::DHM_DATA_W-1:0]    s_axis_tdata,  // channel_index[8:0], source_level[16:9]
  input  logic                              s_axis_tlast,  // last_source
  // changed channel levels
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dhm_pkg::DHM_DATA_W-1:0]    m_axis_tdata,  // out_channel[8:0], out_level[16:9]
  // grand master
  input  logic                              cfg_we_i,
  input  logic [dhm_pkg::DHM_MASTER_W-1:0]  cfg_wdata_i
);
  import dhm_pkg::*;

  dhm_status_t            status;
  dhm_item_t              push_item, q_item;
  logic                   push, q_full, q_valid, pop;
  logic [DHM_CH_W-1:0]    out_ch;
  logic [DHM_LEVEL_W-1:0] out_level;

  // front end: running maximum, master scaling, closing items into the queue
  dhm_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .ch_i        (s_axis_tdata[DHM_CH_W-1:0]),
    .level_i     (s_axis_tdata[DHM_CH_W+DHM_LEVEL_W-1:DHM_CH_W]),
    .last_i      (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_i    (status),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  // short queue so a stalled output does not stall the scan right away
  dhm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // back end: compare against the sent table, update it, emit on change
  dhm_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ch_o    (out_ch),
    .out_level_o (out_level)
  );

  assign m_axis_tdata = {(DHM_DATA_W - DHM_CH_W - DHM_LEVEL_W)'(0), out_level, out_ch};

`ifndef SYNTHESIS
  // no source item is taken while the table is being cleared
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> !s_axis_tready)
    else $error("input accepted during table clear");

  // nothing reaches the output during the clearing pass
  a_no_output_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> !m_axis_tvalid)
    else $error("output valid during table clear");

  // only channels that exist are ever reported
  a_out_channel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, out_ch} < (DHM_CH_W + 1)'(CHANNELS)))
    else $error("output channel out of range");

  // the queue never overflows: a push into a full queue would lose an item
  a_no_queue_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("push into full queue");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dhm_pkg::*;

  // watchdog limit on the total run length, in cycles
  localparam int unsigned CYCLE_LIMIT = 400000;
  // long receiver stall, long enough to fill the block and stall its input
  localparam int unsigned RX_HOLD_CYCLES = 300;
  // settle time after the last expected result
  localparam int unsigned SETTLE_CYCLES = 8;

  // one source level as offered on the slave side
  typedef struct {
    logic [DHM_CH_W-1:0]    ch;
    logic [DHM_LEVEL_W-1:0] lvl;
    bit                     last;
    bit                     drain;  // sender waits for all results before offering it
  } source_item_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [DHM_DATA_W-1:0]   s_axis_tdata = '0;
  logic                    s_axis_tlast = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [DHM_DATA_W-1:0]   m_axis_tdata;
  logic                    cfg_we_i = 1'b0;
  logic [DHM_MASTER_W-1:0] cfg_wdata_i = '0;

  // merger state as the block should hold it, reset values from the start
  logic [DHM_LEVEL_W-1:0]  open_max = '0;
  logic [DHM_LEVEL_W-1:0]  sent_lvl [DHM_CHANNELS];
  logic [DHM_MASTER_W-1:0] grand_master = '0;

  source_item_t source_q [$];         // items waiting to be offered
  dhm_item_t    level_updates_q [$];  // channel updates still to arrive
  dhm_item_t    oldest_update;

  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;

  // handshake seen at the last rising edge
  bit s_taken = 1'b0;
  bit m_taken = 1'b0;

  // sender pacing
  int unsigned tx_gap = 0;
  int unsigned tx_count = 0;
  bit          tx_calm = 1'b0;

  // receiver pacing
  int unsigned rx_wait = 0;
  int unsigned rx_count = 0;
  bit          rx_calm = 1'b1;
  int unsigned rx_hold_left = 0;
  bit          rx_hold_req = 1'b0;
  bit          rx_hold_done = 1'b0;

  // history for repeated groups that should not change anything
  logic [DHM_CH_W-1:0]    prev_ch = '0;
  logic [DHM_LEVEL_W-1:0] prev_max = '0;

  initial begin
    for (int i = 0; i < DHM_CHANNELS; i++) sent_lvl[i] = '0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dmx_htp_merge_master_delta_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // htp merge of one source level; a closing item scales the maximum by the
  // grand master and queues an update only when the sent level changes
  task automatic merge_source(logic [DHM_CH_W-1:0] ch, logic [DHM_LEVEL_W-1:0] lvl,
                              bit last);
    logic [DHM_LEVEL_W+DHM_MASTER_W-1:0] prod;
    logic [DHM_LEVEL_W-1:0]              merged;
    dhm_item_t                           upd;
    if (ch < DHM_CHANNELS && lvl > open_max) open_max = lvl;
    if (last) begin
      merged = open_max;
      open_max = '0;
      if (ch < DHM_CHANNELS) begin
        prod = (merged * grand_master) >> 8;
        // master above full scale saturates
        merged = (prod > 255) ? 8'hFF : prod[DHM_LEVEL_W-1:0];
        if (sent_lvl[ch] != merged) begin
          sent_lvl[ch] = merged;
          upd.ch = ch;
          upd.level = merged;
          level_updates_q = {level_updates_q, upd};
        end
      end
    end
  endtask

  // rising edge: take accepted items on both sides
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_taken <= 1'b0;
      m_taken <= 1'b0;
    end else begin
      s_taken <= s_axis_tvalid && s_axis_tready;
      m_taken <= m_axis_tvalid && m_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        merge_source(s_axis_tdata[DHM_CH_W-1:0],
                     s_axis_tdata[DHM_CH_W+DHM_LEVEL_W-1:DHM_CH_W], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (level_updates_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected update ch %0d level %0d",
                                  m_axis_tdata[DHM_CH_W-1:0],
                                  m_axis_tdata[DHM_CH_W+DHM_LEVEL_W-1:DHM_CH_W]));
        end else begin
          oldest_update = level_updates_q.pop_front();
          if (m_axis_tdata[DHM_CH_W-1:0] !== oldest_update.ch)
            flag_mismatch($sformatf("out_channel %0d, want %0d",
                                    m_axis_tdata[DHM_CH_W-1:0], oldest_update.ch));
          if (m_axis_tdata[DHM_CH_W+DHM_LEVEL_W-1:DHM_CH_W] !== oldest_update.level)
            flag_mismatch($sformatf("out_level %0d on ch %0d, want %0d",
                                    m_axis_tdata[DHM_CH_W+DHM_LEVEL_W-1:DHM_CH_W],
                                    oldest_update.ch, oldest_update.level));
        end
      end
    end
  end

  // sender: holds an item until taken, then waits its drawn gap
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !s_taken)) begin
      if (s_axis_tvalid) begin
        source_q.delete(0);
        tx_count++;
        // switch between idle-free bursts and random gaps now and then
        if (tx_count % 50 == 0) tx_calm = ($urandom_range(0, 2) == 0);
        tx_gap = tx_calm ? 0 : $urandom_range(0, 10);
      end
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (source_q.size() != 0 &&
                   (!source_q[0].drain || level_updates_q.size() == 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, source_q[0].lvl, source_q[0].ch};
        s_axis_tlast  <= source_q[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: a random wait per result, plus one long hold when requested
  always @(negedge clk_i) begin
    if (rx_hold_req && !rx_hold_done) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_done = 1'b1;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_taken) begin
        rx_count++;
        if (rx_count % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic queue_source(logic [DHM_CH_W-1:0] ch, logic [DHM_LEVEL_W-1:0] lvl,
                              bit last, bit drain = 1'b0);
    source_item_t it;
    it.ch = ch;
    it.lvl = lvl;
    it.last = last;
    it.drain = drain;
    source_q = {source_q, it};
  endtask

  // levels lean toward the extremes now and then
  function automatic logic [DHM_LEVEL_W-1:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return DHM_LEVEL_W'($urandom_range(0, 255));
  endfunction

  // mostly well-formed channel groups, some empty channels, repeats that
  // should cause nothing, and groups whose tags disagree
  task automatic queue_random_groups(int unsigned n_items);
    int unsigned            added;
    int unsigned            glen;
    int unsigned            kind;
    logic [DHM_CH_W-1:0]    ch;
    logic [DHM_LEVEL_W-1:0] lvl;
    logic [DHM_LEVEL_W-1:0] gmax;
    added = 0;
    while (added < n_items) begin
      kind = $urandom_range(0, 9);
      // a small hot set of channels so levels get revisited
      ch = $urandom_range(0, 1) ? DHM_CH_W'($urandom_range(0, 15))
                                : DHM_CH_W'($urandom_range(0, DHM_CHANNELS - 1));
      if (kind == 0) begin
        // channel with no sources
        queue_source(ch, 8'h00, 1'b1);
        prev_ch = ch;
        prev_max = 8'h00;
        added++;
      end else if (kind == 1) begin
        // same maximum on the same channel again
        queue_source(prev_ch, prev_max, 1'b1);
        added++;
      end else begin
        glen = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        gmax = '0;
        for (int unsigned k = 0; k < glen; k++) begin
          lvl = pick_level();
          if (lvl > gmax) gmax = lvl;
          if (k == glen - 1)
            queue_source(ch, lvl, 1'b1);
          else if (kind == 2)
            queue_source(DHM_CH_W'($urandom_range(0, DHM_CHANNELS - 1)), lvl, 1'b0);
          else
            queue_source(ch, lvl, 1'b0);
        end
        prev_ch = ch;
        prev_max = gmax;
        added += glen;
      end
    end
  endtask

  // all items offered and taken, every update in, then the pipe settles
  task automatic wait_drained();
    while (source_q.size() != 0 || s_axis_tvalid || level_updates_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_grand_master(logic [DHM_MASTER_W-1:0] value);
    wait_drained();
    cfg_wdata_i = value;
    cfg_we_i = 1'b1;
    grand_master = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // full scale, fresh table of zeros
    set_grand_master(9'd256);
    queue_source(9'd0, 8'hFF, 1'b1);
    queue_source(9'd511, 8'hFF, 1'b1);
    queue_source(9'd511, 8'hFF, 1'b1);       // unchanged, no update
    queue_source(9'd5, 8'd10, 1'b0);
    queue_source(9'd5, 8'd200, 1'b0);
    queue_source(9'd5, 8'd30, 1'b1);         // maximum sits mid-group
    queue_source(9'd6, 8'h00, 1'b1);         // empty channel already at zero
    queue_source(9'd0, 8'h00, 1'b1);         // drop back to zero
    queue_source(9'd9, 8'd77, 1'b0);         // tags differ inside the group
    queue_source(9'd300, 8'd90, 1'b0);
    queue_source(9'd7, 8'd12, 1'b1);
    queue_source(9'd256, 8'd1, 1'b1);
    queue_source(9'd170, 8'hAA, 1'b1);
    queue_source(9'd341, 8'h55, 1'b1);
    queue_source(9'd5, 8'd200, 1'b1);        // same level again
    queue_source(9'd1, 8'd128, 1'b0);
    queue_source(9'd1, 8'h00, 1'b0);
    queue_source(9'd1, 8'hFF, 1'b0);
    queue_source(9'd1, 8'd3, 1'b1);

    // master above full: saturation
    set_grand_master(9'd511);
    queue_source(9'd3, 8'hFF, 1'b1);
    queue_source(9'd4, 8'd1, 1'b1);
    queue_source(9'd8, 8'd128, 1'b1);
    queue_random_groups(150);

    // blackout, then nearly dark
    set_grand_master(9'd0);
    queue_random_groups(100);
    set_grand_master(9'd1);
    queue_random_groups(100);

    // full scale with a long receiver stall and one full drain mid-stream
    set_grand_master(9'd256);
    rx_hold_req = 1'b1;
    queue_random_groups(300);
    queue_source(9'd2, 8'd99, 1'b1, 1'b1);
    queue_random_groups(300);

    set_grand_master(9'd128);
    queue_random_groups(300);
    set_grand_master(9'd257);
    queue_random_groups(200);
    set_grand_master(DHM_MASTER_W'($urandom_range(0, 511)));
    queue_random_groups(400);

    wait_drained();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
